// ===== src/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg: shared constants for the Ramsete tracking law block
// Field widths, fixed-point format, and the sinc series divisor tables.
// ----------------------------------------------------------------------------
package rmst_pkg;

	// Fixed-point format of all velocities and errors.
	localparam int FRAC_BITS = 16;

	// Field widths of the input word.
	localparam int VEL_W  = 24;
	localparam int HEAD_W = 19;
	localparam int COS_W  = 18;

	// Register widths.
	localparam int AGGR_W = 23;
	localparam int ZETA_W = 17;

	// Square root unit: radicand, root and pipeline depth.
	localparam int SQ_IN_W   = 56;
	localparam int SQ_OUT_W  = 28;
	localparam int SQ_STAGES = 14;

	// Sinc series: squared angle, result width and pipeline depth.
	localparam int SINC_TERMS  = 9;
	localparam int SINC_STAGES = 2 * SINC_TERMS;
	localparam int T_W         = 21;
	localparam int R_W         = 19;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 30;

	localparam logic signed [R_W-1:0] ONE_Q = R_W'(1 << FRAC_BITS);

	// Divisor (2n)(2n+1) minus one, for n from nine down to one.
	localparam logic [8:0] SINC_DIV_M1 [SINC_TERMS] = '{
		9'd341, 9'd271, 9'd209, 9'd155, 9'd109, 9'd71, 9'd41, 9'd19, 9'd5
	};

	// Rounded-up reciprocals 2^32 / (2n)(2n+1); exact for dividends below 2^23.
	localparam logic [RECIP_W-1:0] SINC_RECIP [SINC_TERMS] = '{
		30'd12558384, 30'd15790321, 30'd20452226, 30'd27531842, 30'd39045158,
		30'd59652324, 30'd102261127, 30'd214748365, 30'd715827883
	};

endpackage

// ===== src/rmst_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmst_isqrt: pipelined integer square root
// Restoring digit-by-digit root, two result bits per pipeline stage.
// ----------------------------------------------------------------------------
module rmst_isqrt (
	input  logic                           clk,
	input  logic [rmst_pkg::SQ_STAGES-1:0] en,
	input  logic [rmst_pkg::SQ_IN_W-1:0]   rad,
	output logic [rmst_pkg::SQ_OUT_W-1:0]  root
);
	import rmst_pkg::*;

	localparam int REM_W  = SQ_OUT_W + 3;
	localparam int DIGITS = SQ_OUT_W / SQ_STAGES;

	logic [REM_W-1:0]    rem_s  [SQ_STAGES];
	logic [SQ_OUT_W-1:0] root_s [SQ_STAGES];
	logic [SQ_IN_W-1:0]  rad_s  [SQ_STAGES];

	logic [REM_W-1:0]    rem_n  [SQ_STAGES];
	logic [SQ_OUT_W-1:0] root_n [SQ_STAGES];
	logic [SQ_IN_W-1:0]  rad_n  [SQ_STAGES];

	// Each stage brings down two radicand bits per digit and tries 4*root+1.
	always_comb begin
		logic [REM_W-1:0]    rem_w;
		logic [SQ_OUT_W-1:0] root_w;
		logic [SQ_IN_W-1:0]  rad_w;
		logic [REM_W-1:0]    trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (k == 0) begin
				rem_w  = '0;
				root_w = '0;
				rad_w  = rad;
			end else begin
				rem_w  = rem_s[k-1];
				root_w = root_s[k-1];
				rad_w  = rad_s[k-1];
			end
			for (int i = 0; i < DIGITS; i++) begin
				rem_w = {rem_w[REM_W-3:0], rad_w[SQ_IN_W-1 -: 2]};
				rad_w = {rad_w[SQ_IN_W-3:0], 2'b00};
				trial = REM_W'({root_w, 2'b01});
				if (rem_w >= trial) begin
					rem_w  = rem_w - trial;
					root_w = {root_w[SQ_OUT_W-2:0], 1'b1};
				end else begin
					root_w = {root_w[SQ_OUT_W-2:0], 1'b0};
				end
			end
			rem_n[k]  = rem_w;
			root_n[k] = root_w;
			rad_n[k]  = rad_w;
		end
	end

	// Stage registers move only when their stage is enabled.
	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (en[k]) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				rad_s[k]  <= rad_n[k];
			end
		end
	end

	assign root = root_s[SQ_STAGES-1];

endmodule

// ===== src/rmst_sinc.sv =====
// ----------------------------------------------------------------------------
// rmst_sinc: pipelined sinc of the heading error
// Nested series r = 1 - t*r/((2n)(2n+1)), two pipeline stages per term.
// ----------------------------------------------------------------------------
module rmst_sinc (
	input  logic                             clk,
	input  logic [rmst_pkg::SINC_STAGES-1:0] en,
	input  logic [rmst_pkg::T_W-1:0]         t,
	output logic signed [rmst_pkg::R_W-1:0]  sinc
);
	import rmst_pkg::*;

	localparam int P_W  = T_W + 1 + R_W;
	localparam int Q_W  = P_W - FRAC_BITS;
	localparam int U_W  = 23;
	localparam int PR_W = U_W + RECIP_W;

	logic signed [P_W-1:0]  prod_a_s [SINC_TERMS];
	logic [T_W-1:0]         t_a_s    [SINC_TERMS];
	logic [PR_W-1:0]        prod_b_s [SINC_TERMS];
	logic                   neg_b_s  [SINC_TERMS];
	logic [T_W-1:0]         t_b_s    [SINC_TERMS];

	logic signed [R_W-1:0]  r_chain  [SINC_TERMS+1];
	logic [T_W-1:0]         t_chain  [SINC_TERMS+1];
	logic signed [Q_W-1:0]  q_a      [SINC_TERMS];
	logic [U_W-1:0]         u_a      [SINC_TERMS];

	// Floor division by the term divisor: drop the fraction, fold the sign,
	// then multiply by the reciprocal; the next term's value follows.
	always_comb begin
		logic signed [R_W-1:0] quot;
		r_chain[0] = ONE_Q;
		t_chain[0] = t;
		for (int j = 0; j < SINC_TERMS; j++) begin
			q_a[j] = prod_a_s[j][P_W-1:FRAC_BITS];
			if (q_a[j][Q_W-1]) begin
				u_a[j] = U_W'($signed({1'b0, SINC_DIV_M1[j]}) - q_a[j]);
			end else begin
				u_a[j] = U_W'(q_a[j]);
			end
			quot = $signed({1'b0, prod_b_s[j][RECIP_SHIFT +: R_W-1]});
			if (neg_b_s[j]) begin
				r_chain[j+1] = ONE_Q + quot;
			end else begin
				r_chain[j+1] = ONE_Q - quot;
			end
			t_chain[j+1] = t_b_s[j];
		end
	end

	// Even stages multiply t by the running value, odd stages divide.
	always_ff @(posedge clk) begin
		for (int j = 0; j < SINC_TERMS; j++) begin
			if (en[2*j]) begin
				prod_a_s[j] <= $signed({1'b0, t_chain[j]}) * r_chain[j];
				t_a_s[j]    <= t_chain[j];
			end
			if (en[2*j+1]) begin
				prod_b_s[j] <= u_a[j] * SINC_RECIP[j];
				neg_b_s[j]  <= q_a[j][Q_W-1];
				t_b_s[j]    <= t_a_s[j];
			end
		end
	end

	assign sinc = r_chain[SINC_TERMS];

endmodule

// ===== src/ramsete_tracking_law_top.sv =====
// ----------------------------------------------------------------------------
// ramsete_tracking_law_top: Ramsete path-tracking law, fully pipelined
// Input word: velocities and errors signed Q8.16; heading Q3.16, cosine Q2.16.
// Output word: commanded linear and angular velocity, saturated.
// Gains b and zeta are set over an APB-style port: b at address 0,
// zeta at address 4. Write them only while no word is in flight.
// Both word channels use valid/ready. One word is accepted every cycle
// while the receiver does not stall the pipeline.
// The depth is set by the 14-stage square root and the 18-stage sinc
// series, which run side by side. Each stage holds its own valid bit;
// when the receiver stalls, the output word holds, empty stages upstream
// keep filling, and in_ready drops only once the path back to the input
// is full. Reset clears all valid bits and loads b = 2.0, zeta = 0.7.
// ----------------------------------------------------------------------------
module ramsete_tracking_law_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rmst_pkg::VEL_W-1:0]   ref_velocity,
	input  logic signed [rmst_pkg::VEL_W-1:0]   ref_angular_velocity,
	input  logic signed [rmst_pkg::HEAD_W-1:0]  heading_error,
	input  logic signed [rmst_pkg::COS_W-1:0]   heading_error_cosine,
	input  logic signed [rmst_pkg::VEL_W-1:0]   error_x,
	input  logic signed [rmst_pkg::VEL_W-1:0]   error_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_WIDTH-1:0]        cmd_velocity,
	output logic signed [DATA_WIDTH-1:0]        cmd_angular_velocity
);
	import rmst_pkg::*;

	localparam int NS        = 23;
	localparam int ST_SINC0  = 3;
	localparam int ST_SQRT0  = 4;
	localparam int ST_GAIN   = ST_SQRT0 + SQ_STAGES;
	localparam int ST_SINCN  = ST_SINC0 + SINC_STAGES - 1;

	localparam logic REG_AGGR_B    = 1'b0;
	localparam logic REG_DAMP_ZETA = 1'b1;

	localparam logic [AGGR_W-1:0] AGGR_RESET = 23'd131072;
	localparam logic [ZETA_W-1:0] ZETA_RESET = 17'd45875;

	localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

	function automatic logic [DATA_WIDTH-1:0] sat_out(input logic signed [63:0] x);
		if (x > OUT_MAX) begin
			return OUT_MAX[DATA_WIDTH-1:0];
		end else if (x < OUT_MIN) begin
			return OUT_MIN[DATA_WIDTH-1:0];
		end
		return x[DATA_WIDTH-1:0];
	endfunction

	// Configuration registers.
	logic [AGGR_W-1:0] aggr_b_q;
	logic [ZETA_W-1:0] damp_zeta_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aggr_b_q    <= AGGR_RESET;
			damp_zeta_q <= ZETA_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_AGGR_B:    aggr_b_q    <= pwdata[AGGR_W-1:0];
				REG_DAMP_ZETA: damp_zeta_q <= pwdata[ZETA_W-1:0];
				default:       ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[2])
			REG_AGGR_B:    prdata = 32'(aggr_b_q);
			REG_DAMP_ZETA: prdata = 32'(damp_zeta_q);
			default:       prdata = '0;
		endcase
	end

	// Per-stage valid bits; a stage loads when it is empty or its successor moves.
	logic [NS:1] vld_q;
	logic [NS:1] en;

	assign en[NS] = !vld_q[NS] || out_ready;
	for (genvar i = 1; i < NS; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage 1: squares and first products straight from the input word.
	logic signed [47:0] vv_c;
	logic signed [47:0] ww_c;
	logic signed [37:0] ee_c;
	logic signed [41:0] vc_c;
	logic signed [47:0] bvp_c;

	always_comb begin
		vv_c  = ref_velocity * ref_velocity;
		ww_c  = ref_angular_velocity * ref_angular_velocity;
		ee_c  = heading_error * heading_error;
		vc_c  = ref_velocity * heading_error_cosine;
		bvp_c = $signed({1'b0, aggr_b_q}) * ref_velocity;
	end

	logic [46:0]        vv_s1;
	logic [46:0]        ww_s1;
	logic [36:0]        ee_s1;
	logic signed [47:0] bvp_s1;
	logic [53:0]        bvv_s2;
	logic [46:0]        ww_s2;
	logic [T_W-1:0]     t_s2;
	logic [54:0]        rad_s3;
	logic [44:0]        zs_s18;
	logic signed [50:0] bvr_s21;
	logic signed [58:0] bvsey_s22;
	logic [DATA_WIDTH-1:0] vel_s23;
	logic [DATA_WIDTH-1:0] ang_s23;

	// Delay lines for operands used further down the pipeline.
	logic signed [41:0]        vc_s  [1:22];
	logic signed [VEL_W-1:0]   w_s   [1:22];
	logic signed [HEAD_W-1:0]  e_s   [1:18];
	logic signed [VEL_W-1:0]   ex_s  [1:18];
	logic signed [VEL_W-1:0]   ey_s  [1:21];
	logic signed [31:0]        bv_s  [2:20];
	logic signed [54:0]        kex_s [19:22];
	logic signed [49:0]        ke_s  [19:22];

	logic [SQ_OUT_W-1:0]   root;
	logic signed [R_W-1:0] sinc;

	// Square root of w^2 + b*v^2 and the sinc series run in parallel.
	rmst_isqrt u_isqrt (
		.clk  (clk),
		.en   (en[ST_SQRT0 + SQ_STAGES - 1 : ST_SQRT0]),
		.rad  ({1'b0, rad_s3}),
		.root (root)
	);

	rmst_sinc u_sinc (
		.clk  (clk),
		.en   (en[ST_SINCN : ST_SINC0]),
		.t    (t_s2),
		.sinc (sinc)
	);

	// Gain k, its products, and the sinc-weighted cross-track term.
	logic [29:0]        k_c;
	logic signed [54:0] kex_c;
	logic signed [49:0] ke_c;
	logic signed [50:0] bvr_c;
	logic signed [58:0] bvsey_c;

	always_comb begin
		k_c     = zs_s18[44:15];
		kex_c   = $signed({1'b0, k_c}) * ex_s[18];
		ke_c    = $signed({1'b0, k_c}) * e_s[18];
		bvr_c   = bv_s[20] * sinc;
		bvsey_c = $signed(bvr_s21[50:16]) * ey_s[21];
	end

	// Final sums, floor rescale and saturation.
	logic signed [55:0] vel_sum;
	logic signed [44:0] ang_sum;

	always_comb begin
		vel_sum = {{14{vc_s[22][41]}}, vc_s[22]} + {kex_s[22][54], kex_s[22]};
		ang_sum = {{21{w_s[22][VEL_W-1]}}, w_s[22]}
			+ {{11{ke_s[22][49]}}, ke_s[22][49:16]}
			+ {{2{bvsey_s22[58]}}, bvsey_s22[58:16]};
	end

	// Pipeline data registers.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			vv_s1  <= vv_c[46:0];
			ww_s1  <= ww_c[46:0];
			ee_s1  <= ee_c[36:0];
			bvp_s1 <= bvp_c;
			vc_s[1]  <= vc_c;
			w_s[1]   <= ref_angular_velocity;
			e_s[1]   <= heading_error;
			ex_s[1]  <= error_x;
			ey_s[1]  <= error_y;
		end
		if (en[2]) begin
			bvv_s2  <= aggr_b_q * vv_s1[46:FRAC_BITS];
			ww_s2   <= ww_s1;
			t_s2    <= ee_s1[36:FRAC_BITS];
			bv_s[2] <= bvp_s1[47:FRAC_BITS];
		end
		if (en[3]) begin
			rad_s3 <= 55'(ww_s2) + 55'(bvv_s2);
		end
		if (en[ST_GAIN]) begin
			zs_s18 <= damp_zeta_q * root;
		end
		if (en[19]) begin
			kex_s[19] <= kex_c;
			ke_s[19]  <= ke_c;
		end
		if (en[21]) begin
			bvr_s21 <= bvr_c;
		end
		if (en[22]) begin
			bvsey_s22 <= bvsey_c;
		end
		if (en[NS]) begin
			vel_s23 <= sat_out({{24{vel_sum[55]}}, vel_sum[55:FRAC_BITS]});
			ang_s23 <= sat_out({{19{ang_sum[44]}}, ang_sum});
		end
		for (int i = 2; i <= 22; i++) begin
			if (en[i]) begin
				vc_s[i] <= vc_s[i-1];
				w_s[i]  <= w_s[i-1];
			end
		end
		for (int i = 2; i <= 18; i++) begin
			if (en[i]) begin
				e_s[i]  <= e_s[i-1];
				ex_s[i] <= ex_s[i-1];
			end
		end
		for (int i = 2; i <= 21; i++) begin
			if (en[i]) begin
				ey_s[i] <= ey_s[i-1];
			end
		end
		for (int i = 3; i <= 20; i++) begin
			if (en[i]) begin
				bv_s[i] <= bv_s[i-1];
			end
		end
		for (int i = 20; i <= 22; i++) begin
			if (en[i]) begin
				kex_s[i] <= kex_s[i-1];
				ke_s[i]  <= ke_s[i-1];
			end
		end
	end

	assign cmd_velocity         = vel_s23;
	assign cmd_angular_velocity = ang_s23;

	// With the output stage empty, the whole path back to the input is open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while the output stage is empty");

	// An accepted word occupies the first stage on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted word missing from the first stage");

	// A word in front of an empty output stage moves into it.
	a_last_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS-1] && !vld_q[NS]) |=> vld_q[NS])
		else $error("word failed to reach the output stage");

	// A blocked first stage keeps its word.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[1] && !en[1]) |=> vld_q[1])
		else $error("word lost from a stalled first stage");

endmodule

// ===== tb/sv/ramsete_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramsete_checker: prediction and comparison for the Ramsete tracking law
// Watches the input and output word channels and the gain register writes,
// computes the expected commands in exact fixed point, and counts mismatches and unexpected words.
// ----------------------------------------------------------------------------
module ramsete_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [rmst_pkg::VEL_W-1:0]   ref_velocity,
	input  logic signed [rmst_pkg::VEL_W-1:0]   ref_angular_velocity,
	input  logic signed [rmst_pkg::HEAD_W-1:0]  heading_error,
	input  logic signed [rmst_pkg::COS_W-1:0]   heading_error_cosine,
	input  logic signed [rmst_pkg::VEL_W-1:0]   error_x,
	input  logic signed [rmst_pkg::VEL_W-1:0]   error_y,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [31:0]                  cmd_velocity,
	input  logic signed [31:0]                  cmd_angular_velocity,
	output int                                  fail_count,
	output int                                  pending
);
	import rmst_pkg::*;

	localparam logic [2:0] ADDR_AGGR = 3'd0;
	localparam logic [2:0] ADDR_ZETA = 3'd4;
	localparam longint GAIN_MAX = (64'sd1 <<< 38) - 1;

	typedef struct packed {
		logic signed [31:0] vel;
		logic signed [31:0] ang;
	} command_t;

	logic [AGGR_W-1:0] gain_b;
	logic [ZETA_W-1:0] gain_zeta;
	command_t cmd_q[$];

	assign pending = cmd_q.size();

	// Floor division by a positive divisor.
	function automatic longint fdiv(longint x, longint d);
		if (x >= 0)
			return x / d;
		return -((-x + d - 1) / d);
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint int_root(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return longint'(r);
	endfunction

	// Nested Taylor series of sin(e)/e in Q16.16.
	function automatic longint sinc_of(longint e);
		longint one;
		longint t;
		longint r;
		one = 64'sd1 <<< FRAC_BITS;
		r = one;
		if (e > 4 * one)
			e = 4 * one;
		if (e < -4 * one)
			e = -4 * one;
		t = fdiv(e * e, one);
		for (int n = 9; n >= 1; n--)
			r = one - fdiv(t * r, longint'(2 * n) * longint'(2 * n + 1) * one);
		return r;
	endfunction

	function automatic command_t tracking_law(longint v, longint w, longint e,
			longint c, longint ex, longint ey);
		command_t res;
		longint one;
		longint b;
		longint z;
		longint k;
		longint bvs;
		logic [63:0] rad;
		one = 64'sd1 <<< FRAC_BITS;
		b = longint'(gain_b);
		z = longint'(gain_zeta);
		rad = 64'(w * w) + 64'(b * fdiv(v * v, one));
		k = fdiv(2 * z * int_root(rad), one);
		if (k > GAIN_MAX)
			k = GAIN_MAX;
		bvs = fdiv(fdiv(b * v, one) * sinc_of(e), one);
		res.vel = 32'(sat32(fdiv(v * c + k * ex, one)));
		res.ang = 32'(sat32(w + fdiv(k * e, one) + fdiv(bvs * ey, one)));
		return res;
	endfunction

	// Register shadow, input prediction and output comparison.
	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			gain_b <= AGGR_W'(131072);
			gain_zeta <= ZETA_W'(45875);
			fail_count <= 0;
			cmd_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_AGGR)
					gain_b <= pwdata[AGGR_W-1:0];
				else if (paddr == ADDR_ZETA)
					gain_zeta <= pwdata[ZETA_W-1:0];
			end
			if (in_valid && in_ready)
				cmd_q.push_back(tracking_law(ref_velocity, ref_angular_velocity,
					heading_error, heading_error_cosine, error_x, error_y));
			if (out_valid && out_ready) begin
				if (cmd_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected word: vel %0d ang %0d",
							cmd_velocity, cmd_angular_velocity);
				end else begin
					want = cmd_q.pop_front();
					if (want.vel !== cmd_velocity || want.ang !== cmd_angular_velocity) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: vel exp %0d got %0d, ang exp %0d got %0d",
								want.vel, cmd_velocity, want.ang, cmd_angular_velocity);
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the Ramsete tracking law block
// Drives directed and random words under several gain settings with random
// gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import rmst_pkg::*;

	localparam logic [2:0] ADDR_AGGR = 3'd0;
	localparam logic [2:0] ADDR_ZETA = 3'd4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LATENCY = 23;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic signed [VEL_W-1:0] ref_velocity = '0, ref_angular_velocity = '0;
	logic signed [HEAD_W-1:0] heading_error = '0;
	logic signed [COS_W-1:0] heading_error_cosine = '0;
	logic signed [VEL_W-1:0] error_x = '0, error_y = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] cmd_velocity, cmd_angular_velocity;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	ramsete_tracking_law_top dut (.*);
	ramsete_checker chk (.*);

	// Run-time limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL ramsete_tracking_law_top");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

	task automatic write_reg(logic [2:0] addr, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Stop offering words and wait until every expected word has come out.
	task automatic drain;
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Offer one word and hold it until accepted; called at a falling edge,
	// returns at the falling edge after acceptance with valid still high.
	task automatic send_word(logic [23:0] v, logic [23:0] w, logic [18:0] e,
			logic [17:0] c, logic [23:0] ex, logic [23:0] ey);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		ref_velocity <= v; ref_angular_velocity <= w; heading_error <= e;
		heading_error_cosine <= c; error_x <= ex; error_y <= ey;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [23:0] rnd_wide();
		case ($urandom_range(3))
			0: return 24'($signed($urandom_range(131072)) - 65536);
			1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_word;
		logic [18:0] e;
		logic [17:0] c;
		e = 19'($signed($urandom_range(411774)) - 205887);
		c = 18'($signed($urandom_range(131072)) - 65536);
		send_word(rnd_wide(), rnd_wide(), e, c, rnd_wide(), rnd_wide());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed words under reset gains: extremes, zero angle, sign bits.
		send_word(0, 0, 0, 65536, 0, 0);
		send_word(24'h7fffff, 24'h7fffff, 19'd205887, 18'd65536, 24'h7fffff, 24'h7fffff);
		send_word(24'h800000, 24'h800000, -19'sd205887, -18'sd65536, 24'h800000, 24'h800000);
		send_word(24'h7fffff, 24'h800000, 0, 0, 24'h800000, 24'h7fffff);
		send_word(65536, 0, 19'd102943, 0, 65536, 65536);
		send_word(-24'sd65536, 65536, -19'sd1, 18'd65535, -24'sd1, 1);
		send_word(24'h555555, 24'haaaaaa, 19'h2aaaa, 18'h15555, 24'h555555, 24'haaaaaa);
		send_word(24'haaaaaa, 24'h555555, -19'sd1234, 18'h2aaaa, 24'haaaaaa, 24'h555555);
		drain();

		// Extreme gains.
		write_reg(ADDR_AGGR, 4194304);
		write_reg(ADDR_ZETA, 65536);
		send_word(24'h7fffff, 24'h7fffff, 19'd205887, 18'd65536, 24'h7fffff, 24'h800000);
		send_word(24'h800000, 24'h800000, -19'sd205887, -18'sd65536, 24'h800000, 24'h7fffff);
		send_word(24'h123456, 24'hfedcba, 19'd50000, 18'd30000, 24'h654321, 24'h0abcde);
		drain();
		write_reg(ADDR_AGGR, 0);
		write_reg(ADDR_ZETA, 0);
		send_word(24'h7fffff, 24'h7fffff, 19'd205887, 18'd65536, 24'h7fffff, 24'h7fffff);
		send_word(24'h800000, 24'h800000, 19'd1000, 18'd100, 24'h800000, 24'h800000);
		drain();
		write_reg(ADDR_AGGR, 32'h7fffff);
		write_reg(ADDR_ZETA, 32'h1ffff);
		send_word(24'h7fffff, 24'h800000, 19'd205887, 18'd65536, 24'h7fffff, 24'h7fffff);
		send_word(24'h800000, 24'h7fffff, -19'sd205887, -18'sd65536, 24'h800000, 24'h800000);
		drain();

		// Random phases: three idling profiles, each with fresh gains.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 29 : (ph == 1) ? 88 : 0;
			recv_idle = (ph == 0) ? 88 : (ph == 1) ? 29 : 0;
			write_reg(ADDR_AGGR, $urandom_range(4194304));
			write_reg(ADDR_ZETA, $urandom_range(65536));
			for (int i = 0; i < 180; i++) begin
				if (ph == 2 && i == 60)
					hold_off = 1;
				if (ph == 2 && i == 120)
					drain();
				random_word();
			end
			drain();
		end

		send_idle = 0;
		recv_idle = 0;
		drain();
		if (fail_count == 0)
			$display("PASS ramsete_tracking_law_top");
		else
			$display("FAIL ramsete_tracking_law_top");
		$finish;
	end

	// Long receiver hold-off so the pipeline fills and stalls the input.
	always @(posedge clk) begin
		int held;
		if (hold_off) begin
			for (held = 0; held < 80; held++)
				@(posedge clk);
			hold_off <= 0;
			while (1)
				@(posedge clk);
		end
	end
endmodule
